>>> hdl/rcst_pkg.sv
// Package: types, widths and codes shared by the region chunk slot table.
`default_nettype none
package rcst_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int MAX_CHUNKS_DEF = 64;

  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 41;
  localparam int OWNER_W = 22;
  localparam int SLOT_W  = 8;
  localparam int STAT_W  = 3;

  localparam logic [LEN_W-1:0] CHUNK_MIN   = LEN_W'(64'd4096);
  localparam logic [LEN_W-1:0] CHUNK_MAX   = LEN_W'(64'h100_0000_0000);
  localparam logic [LEN_W-1:0] CHUNK_RESET = LEN_W'(64'd1073741824);

  localparam logic ACT_REGISTER = 1'b0;
  localparam logic ACT_RELEASE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_TOO_MANY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  start;
    logic [LEN_W-1:0]   length;
    logic [OWNER_W-1:0] owner;
    logic               sliced;
  } slot_entry_t;

endpackage
`default_nettype wire

>>> hdl/rcst_if.sv
// Interfaces: request channel and result channel with valid/ready.
`default_nettype none
interface rcst_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [rcst_pkg::OWNER_W-1:0] owner_id;
  logic [rcst_pkg::ADDR_W-1:0]  region_start;
  logic [rcst_pkg::ADDR_W-1:0]  region_size;
  modport source (output valid, action, owner_id, region_start, region_size, input ready);
  modport sink   (input valid, action, owner_id, region_start, region_size, output ready);
endinterface

interface rcst_res_if;
  logic                        valid;
  logic                        ready;
  logic [rcst_pkg::SLOT_W-1:0]  slot_number;
  logic [rcst_pkg::ADDR_W-1:0]  chunk_start;
  logic [rcst_pkg::LEN_W-1:0]   chunk_length;
  logic                        is_slice;
  logic [rcst_pkg::STAT_W-1:0]  status;
  logic                        last;
  modport source (output valid, slot_number, chunk_start, chunk_length, is_slice, status,
                  last, input ready);
  modport sink   (input valid, slot_number, chunk_start, chunk_length, is_slice, status,
                  last, output ready);
endinterface
`default_nettype wire

>>> hdl/rcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/region_chunk_slot_table.sv
// Top level: region register/release engine over a RAM slot table.
//
//  channel | dir | handshake        | beat
//  in_ch   | in  | valid/ready      | action, owner_id, region_start, region_size
//  out_ch  | out | valid/ready      | one result per chunk, last on the final one
//  cfg_*   | in  | cfg_we, no stall | chunk size in bytes
//
// After reset a clearing pass walks the table with in_ch.ready low.
// One request at a time: a counting loop sizes the request; over MAX_CHUNKS chunks it
// emits a single too-many beat, else each chunk scans the slot RAM one entry a cycle
// until a hit or the table's end, then writes back on a hit and emits its beat.
// A stalled out_ch holds the engine in its emit step; no beat is dropped.
`default_nettype none
module region_chunk_slot_table #(
  parameter int SLOT_COUNT = rcst_pkg::SLOT_COUNT_DEF,
  parameter int MAX_CHUNKS = rcst_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  rcst_req_if.sink                       in_ch,
  rcst_res_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [rcst_pkg::LEN_W-1:0] cfg_wdata
);
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW = rcst_pkg::ADDR_W;
  localparam int LW = rcst_pkg::LEN_W;
  localparam int EW = $bits(rcst_pkg::slot_entry_t);

  rcst_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]               csz_r;
  logic                        act_r;
  logic [rcst_pkg::OWNER_W-1:0] owner_r;
  logic [AW-1:0]               cstart_r;
  logic [AW-1:0]               rem_r;
  logic [AW-1:0]               cnt_rem_r;
  logic [CW-1:0]               cnt_r;
  logic                        sliced_r;
  logic                        many_r;
  logic [IW:0]                 scan_idx_r;
  logic                        pend_r;
  logic [IW-1:0]               pend_idx_r;
  logic                        found_r;
  logic [IW-1:0]               found_idx_r;
  logic [IW-1:0]               clr_idx_r;

  logic                        out_valid_r;
  logic [rcst_pkg::SLOT_W-1:0]  out_slot_r;
  logic [AW-1:0]               out_start_r;
  logic [LW-1:0]               out_len_r;
  logic                        out_slice_r;
  logic [rcst_pkg::STAT_W-1:0]  out_status_r;
  logic                        out_last_r;

  // RAM ports
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  rcst_pkg::slot_entry_t       ram_wdata;
  logic [EW-1:0]               ram_rdata;
  rcst_pkg::slot_entry_t       rd_entry;

  rcst_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );
  assign rd_entry = rcst_pkg::slot_entry_t'(ram_rdata);

  // Current chunk: full chunk while more than one chunk of bytes remains
  logic [AW-1:0] csz_w;
  logic          more;
  logic [LW-1:0] clen;
  logic          clast;
  assign csz_w = AW'(csz_r);
  assign more  = rem_r > csz_w;
  assign clen  = more ? csz_r : rem_r[LW-1:0];
  assign clast = !more;

  // Scan hit on the entry returned this cycle
  logic hit;
  logic scan_end;
  always_comb begin
    if (act_r == rcst_pkg::ACT_REGISTER) begin
      hit = pend_r && !rd_entry.valid;
    end else begin
      hit = pend_r && rd_entry.valid && rd_entry.start == cstart_r &&
            rd_entry.length == clen;
    end
  end
  assign scan_end = pend_r && (pend_idx_r == IW'(SLOT_COUNT - 1));

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcst_pkg::S_CLEAR: begin
        if (clr_idx_r == IW'(SLOT_COUNT - 1)) state_nxt = rcst_pkg::S_IDLE;
      end
      rcst_pkg::S_IDLE: begin
        if (in_fire) state_nxt = rcst_pkg::S_COUNT;
      end
      rcst_pkg::S_COUNT: begin
        if (cnt_rem_r <= csz_w) state_nxt = rcst_pkg::S_SCAN;
        else if (cnt_r == CW'(MAX_CHUNKS - 1)) state_nxt = rcst_pkg::S_EMIT;
      end
      rcst_pkg::S_SCAN: begin
        if (hit || scan_end) state_nxt = rcst_pkg::S_EMIT;
      end
      rcst_pkg::S_EMIT: begin
        if (out_free) begin
          if (many_r || clast) state_nxt = rcst_pkg::S_IDLE;
          else state_nxt = rcst_pkg::S_SCAN;
        end
      end
      default: state_nxt = rcst_pkg::S_CLEAR;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ch.ready = (state_r == rcst_pkg::S_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = found_idx_r;
    ram_wdata   = '0;
    case (state_r)
      rcst_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
      end
      rcst_pkg::S_EMIT: begin
        // write back: claim on register, drop the valid bit on release
        ram_we           = out_free && !many_r && found_r;
        ram_wdata.valid  = (act_r == rcst_pkg::ACT_REGISTER);
        ram_wdata.start  = cstart_r;
        ram_wdata.length = clen;
        ram_wdata.owner  = owner_r;
        ram_wdata.sliced = sliced_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcst_pkg::S_CLEAR;
      csz_r       <= rcst_pkg::CHUNK_RESET;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // clamp the chunk size once, on the write
      if (cfg_we) begin
        if (cfg_wdata < rcst_pkg::CHUNK_MIN) csz_r <= rcst_pkg::CHUNK_MIN;
        else if (cfg_wdata > rcst_pkg::CHUNK_MAX) csz_r <= rcst_pkg::CHUNK_MAX;
        else csz_r <= cfg_wdata;
      end

      // load a beat when the output register frees up, else drop it once taken
      if (state_r == rcst_pkg::S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        rcst_pkg::S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
        rcst_pkg::S_IDLE: begin
          if (in_fire) begin
            act_r     <= in_ch.action;
            owner_r   <= in_ch.owner_id;
            cstart_r  <= in_ch.region_start;
            rem_r     <= in_ch.region_size;
            cnt_rem_r <= in_ch.region_size;
            cnt_r     <= '0;
            many_r    <= 1'b0;
            sliced_r  <= in_ch.region_size > csz_w;
          end
        end
        rcst_pkg::S_COUNT: begin
          // advance one chunk per cycle until the rest fits or the chunk limit is hit
          if (cnt_rem_r <= csz_w) begin
            scan_idx_r <= '0;
            pend_r     <= 1'b0;
          end else begin
            cnt_rem_r <= cnt_rem_r - csz_w;
            cnt_r     <= cnt_r + 1'b1;
            if (cnt_r == CW'(MAX_CHUNKS - 1)) many_r <= 1'b1;
          end
        end
        rcst_pkg::S_SCAN: begin
          if (scan_idx_r < (IW+1)'(SLOT_COUNT)) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_idx_r[IW-1:0];
            scan_idx_r <= scan_idx_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          found_r     <= hit;
          found_idx_r <= pend_idx_r;
        end
        rcst_pkg::S_EMIT: begin
          if (out_free) begin
            if (many_r) begin
              out_slot_r   <= '0;
              out_start_r  <= cstart_r;
              out_len_r    <= '0;
              out_slice_r  <= 1'b1;
              out_status_r <= rcst_pkg::ST_TOO_MANY;
              out_last_r   <= 1'b1;
            end else begin
              out_slot_r   <= found_r ? rcst_pkg::SLOT_W'({{rcst_pkg::SLOT_W{1'b0}},
                                                           found_idx_r}) : '0;
              out_start_r  <= cstart_r;
              out_len_r    <= clen;
              out_slice_r  <= sliced_r;
              out_last_r   <= clast;
              if (act_r == rcst_pkg::ACT_REGISTER) begin
                out_status_r <= found_r ? rcst_pkg::ST_STORED : rcst_pkg::ST_FULL;
              end else begin
                out_status_r <= found_r ? rcst_pkg::ST_RELEASED : rcst_pkg::ST_NOT_FOUND;
              end
            end
            // step to the next chunk, address wraps at 48 bits
            rem_r      <= rem_r - csz_w;
            cstart_r   <= cstart_r + csz_w;
            scan_idx_r <= '0;
            pend_r     <= 1'b0;
          end
        end
        default: pend_r <= 1'b0;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot_number  = out_slot_r;
  assign out_ch.chunk_start  = out_start_r;
  assign out_ch.chunk_length = out_len_r;
  assign out_ch.is_slice     = out_slice_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.last         = out_last_r;
endmodule
`default_nettype wire

>>> tb/sv/region_chunk_slot_table_chk.sv
// Checker: watches both channels and the chunk size port, predicts each beat, compares.
module region_chunk_slot_table_chk
  import rcst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  rcst_req_if              req,
  rcst_res_if              res,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              slice;
    status_t           status;
    logic              last;
  } chunk_beat_t;

  chunk_beat_t       pending_beats[$];
  logic [LEN_W-1:0]  cfg_chunk;
  bit                slot_busy   [SLOT_COUNT_DEF];
  logic [ADDR_W-1:0] slot_base   [SLOT_COUNT_DEF];
  logic [LEN_W-1:0]  slot_span   [SLOT_COUNT_DEF];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report(string msg);
    fail_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic void push_beat(int slot, logic [63:0] start, logic [63:0] length,
                                    logic slice, status_t st, logic last);
    chunk_beat_t b;
    b.slot   = slot[SLOT_W-1:0];
    b.start  = start[ADDR_W-1:0];
    b.length = length[LEN_W-1:0];
    b.slice  = slice;
    b.status = st;
    b.last   = last;
    pending_beats.push_back(b);
  endfunction

  // Split the region into chunks and walk the slot table once per chunk.
  function automatic void split_and_apply(logic act, logic [ADDR_W-1:0] rstart,
                                          logic [ADDR_W-1:0] rsize);
    logic [63:0] csz, full, rem, count, cstart, clen;
    logic        sliced, last;
    int          hit;
    csz = 64'(cfg_chunk);
    if (csz < 64'(CHUNK_MIN)) csz = 64'(CHUNK_MIN);
    if (csz > 64'(CHUNK_MAX)) csz = 64'(CHUNK_MAX);
    if (64'(rsize) > csz) begin
      full   = 64'(rsize) / csz;
      rem    = 64'(rsize) % csz;
      count  = full + ((rem != 0) ? 64'd1 : 64'd0);
      sliced = 1'b1;
    end else begin
      full   = 0;
      rem    = 64'(rsize);
      count  = 1;
      sliced = 1'b0;
    end
    if (count > 64'(MAX_CHUNKS_DEF)) begin
      push_beat(0, 64'(rstart), 0, 1'b1, ST_TOO_MANY, 1'b1);
      return;
    end
    for (longint i = 0; i < longint'(count); i++) begin
      cstart = (64'(rstart) + 64'(i) * csz) & 64'hFFFF_FFFF_FFFF;
      clen   = (64'(i) < full) ? csz : rem;
      last   = (64'(i) + 1 == count);
      hit    = -1;
      for (int s = 0; s < SLOT_COUNT_DEF && hit < 0; s++) begin
        if (act == ACT_REGISTER) begin
          if (!slot_busy[s]) hit = s;
        end else if (slot_busy[s] && slot_base[s] == cstart[ADDR_W-1:0] &&
                     slot_span[s] == clen[LEN_W-1:0]) begin
          hit = s;
        end
      end
      if (act == ACT_REGISTER) begin
        if (hit < 0) begin
          push_beat(0, cstart, clen, sliced, ST_FULL, last);
        end else begin
          slot_busy[hit] = 1'b1;
          slot_base[hit] = cstart[ADDR_W-1:0];
          slot_span[hit] = clen[LEN_W-1:0];
          push_beat(hit, cstart, clen, sliced, ST_STORED, last);
        end
      end else begin
        if (hit < 0) begin
          push_beat(0, cstart, clen, sliced, ST_NOT_FOUND, last);
        end else begin
          slot_busy[hit] = 1'b0;
          push_beat(hit, cstart, clen, sliced, ST_RELEASED, last);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    chunk_beat_t e;
    if (!rst_n) begin
      cfg_chunk = CHUNK_RESET;
      pending_beats.delete();
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_beats.size() == 0) begin
          report($sformatf("beat with nothing expected, start %h", res.chunk_start));
        end else begin
          e = pending_beats.pop_front();
          if (res.slot_number !== e.slot)
            report($sformatf("slot_number %0d, want %0d", res.slot_number, e.slot));
          if (res.chunk_start !== e.start)
            report($sformatf("chunk_start %h, want %h", res.chunk_start, e.start));
          if (res.chunk_length !== e.length)
            report($sformatf("chunk_length %h, want %h", res.chunk_length, e.length));
          if (res.is_slice !== e.slice)
            report($sformatf("is_slice %b, want %b", res.is_slice, e.slice));
          if (res.status !== e.status)
            report($sformatf("status %0d, want %s", res.status, e.status.name()));
          if (res.last !== e.last)
            report($sformatf("last %b, want %b", res.last, e.last));
        end
      end
      if (req.valid && req.ready)
        split_and_apply(req.action, req.region_start, req.region_size);
      if (cfg_we) cfg_chunk = cfg_wdata;
    end
    outstanding = pending_beats.size();
  end

endmodule

>>> tb/sv/region_chunk_slot_table_tb.sv
// Testbench top: clock, reset, stimulus, chunk size phases and the verdict.
module region_chunk_slot_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcst_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } region_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int               fail_count;
  int               outstanding;

  // Idle percentages for each side; the receiver also honors a one-shot long hold.
  int               send_idle_pct;
  int               recv_idle_pct;
  int               recv_hold_cycles;
  logic [63:0]      eff_chunk;
  region_t          live_regions[$];

  rcst_req_if req_ch();
  rcst_res_if res_ch();

  region_chunk_slot_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  region_chunk_slot_table_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .res         (res_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard ceiling on the run: a hung handshake ends up here.
  initial begin
    #400ms;
    $display("[region_chunk_slot_table] ERROR");
    $finish;
  end

  // Receiver: drive ready at the falling edge; a long hold lets the block back up
  // and stall its input while the sender keeps offering beats.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request beat and hold it until the block takes it.
  task automatic send_request(logic act, logic [OWNER_W-1:0] owner,
                              logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.owner_id     <= owner;
    req_ch.region_start <= start;
    req_ch.region_size  <= size;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait for every expected beat, then let the engine settle.
  task automatic drain;
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic release_all_live;
    region_t r;
    while (live_regions.size() != 0) begin
      r = live_regions.pop_front();
      send_request(ACT_RELEASE, OWNER_W'($urandom), r.start, r.size);
    end
  endtask

  // Write the chunk size while idle and keep the clamped value for sizing regions.
  task automatic set_chunk(logic [LEN_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    eff_chunk = 64'(value);
    if (eff_chunk < 64'(CHUNK_MIN)) eff_chunk = 64'(CHUNK_MIN);
    if (eff_chunk > 64'(CHUNK_MAX)) eff_chunk = 64'(CHUNK_MAX);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed traffic: register a few chunks, release what is live,
  // with a slice of raw noise that usually trips the too-many-chunks path.
  task automatic random_request;
    int          roll, idx, nch;
    logic [63:0] size;
    region_t     r;
    roll = $urandom_range(99);
    if (roll < 10) begin
      send_request(1'($urandom), OWNER_W'($urandom), ADDR_W'(rand64()), ADDR_W'(rand64()));
    end else if (roll < 45 && live_regions.size() != 0) begin
      idx = $urandom_range(live_regions.size() - 1);
      r = live_regions[idx];
      live_regions.delete(idx);
      send_request(ACT_RELEASE, OWNER_W'($urandom), r.start, r.size);
    end else begin
      nch = ($urandom_range(19) == 0) ? $urandom_range(5, 64) : $urandom_range(1, 4);
      if ($urandom_range(3) == 0) size = 64'(nch) * eff_chunk;
      else size = 64'(nch - 1) * eff_chunk + 1 + (rand64() % eff_chunk);
      r.start = ADDR_W'(rand64());
      r.size  = ADDR_W'(size);
      live_regions.push_back(r);
      send_request(ACT_REGISTER, OWNER_W'($urandom), r.start, r.size);
    end
  endtask

  initial begin
    logic [63:0] g;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_REGISTER;
    req_ch.owner_id     = '0;
    req_ch.region_start = '0;
    req_ch.region_size  = '0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    recv_hold_cycles    = 0;
    eff_chunk           = 64'(CHUNK_RESET);
    rst_n               = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset chunk size of 1 GiB.
    g = 64'(CHUNK_RESET);
    send_request(ACT_REGISTER, '0, '0, '0);                           // empty region
    send_request(ACT_REGISTER, '1, 48'h0000_4000_0000, ADDR_W'(g));   // one full chunk
    send_request(ACT_REGISTER, 22'h155555, 48'h0001_0000_0000, ADDR_W'(3 * g));
    send_request(ACT_REGISTER, 22'h2AAAAA, 48'h0010_0000_0000, ADDR_W'(g + 5));
    send_request(ACT_REGISTER, '0, 48'h0100_0000_0000, ADDR_W'(65 * g + 1));
    send_request(ACT_REGISTER, '0, 48'hFFFF_FFFF_F000, ADDR_W'(2 * g + 1)); // wraps
    send_request(ACT_REGISTER, '0, 48'h2000_0000_0000, ADDR_W'(64 * g));
    send_request(ACT_REGISTER, '1, '1, '1);                           // all ones
    send_request(ACT_RELEASE, '0, 48'h0001_0000_0000, ADDR_W'(3 * g));
    send_request(ACT_RELEASE, '0, 48'h0001_0000_0000, ADDR_W'(3 * g)); // now gone
    send_request(ACT_RELEASE, '0, 48'hFFFF_FFFF_F000, ADDR_W'(2 * g + 1));
    send_request(ACT_RELEASE, '0, '0, '0);
    send_request(ACT_RELEASE, '0, 48'h2000_0000_0000, ADDR_W'(64 * g));
    send_request(ACT_RELEASE, '0, 48'h0000_4000_0000, ADDR_W'(g));
    send_request(ACT_RELEASE, '0, 48'h0010_0000_0000, ADDR_W'(g + 5));

    // Zero chunk size acts as the minimum; overfill the table, then empty it.
    set_chunk('0);
    for (int k = 0; k < 5; k++)
      send_request(ACT_REGISTER, OWNER_W'(k), ADDR_W'(k) << 32, ADDR_W'(64 * 4096));
    for (int k = 0; k < 5; k++)
      send_request(ACT_RELEASE, '0, ADDR_W'(k) << 32, ADDR_W'(64 * 4096));

    // All ones clamps to the largest chunk.
    set_chunk('1);
    send_request(ACT_REGISTER, '0, 48'h8000_0000_0000, ADDR_W'(3 * eff_chunk + 7));
    send_request(ACT_RELEASE, '0, 48'h8000_0000_0000, ADDR_W'(3 * eff_chunk + 7));

    // Phase one: minimum chunk, sender idles lightly, receiver heavily.
    set_chunk(LEN_W'(4096));
    send_idle_pct = 20;
    recv_idle_pct = 59;
    for (int n = 0; n < 80; n++) begin
      if (n == 30) recv_hold_cycles = 3000;
      random_request();
    end
    release_all_live();

    // Hold the sender until everything has drained before going on.
    drain();

    // Phase two: a random chunk size, idling swapped.
    set_chunk(LEN_W'($urandom_range(4096, 1 << 30)) | LEN_W'(rand64()) >> $urandom_range(40));
    send_idle_pct = 59;
    recv_idle_pct = 20;
    for (int n = 0; n < 80; n++) random_request();
    release_all_live();

    // Phase three: maximum chunk, both sides at full rate.
    set_chunk(LEN_W'(CHUNK_MAX));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 80; n++) random_request();
    release_all_live();

    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("[region_chunk_slot_table] OK");
    end else begin
      $display("[region_chunk_slot_table] ERROR");
    end
    $finish;
  end

endmodule
